// ----- rtl/text_terminal_cursor_engine_defines.svh -----
// assertion macros for the text terminal cursor engine
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tte assertion failed");
`define TTE_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tte forbidden condition seen");
`else
`define TTE_ASSERT(lbl, clk, rst_n, prop)
`define TTE_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/tte_pkg.sv -----
// types, codes and tables shared by the text terminal cursor engine
package tte_pkg;

    localparam int unsigned DEF_COLS = 80;
    localparam int unsigned DEF_ROWS = 25;

    localparam logic [3:0] OP_PUT    = 4'd0;
    localparam logic [3:0] OP_UP     = 4'd1;
    localparam logic [3:0] OP_DOWN   = 4'd2;
    localparam logic [3:0] OP_LEFT   = 4'd3;
    localparam logic [3:0] OP_RIGHT  = 4'd4;
    localparam logic [3:0] OP_SETPOS = 4'd5;
    localparam logic [3:0] OP_CLS    = 4'd6;
    localparam logic [3:0] OP_CLL    = 4'd7;
    localparam logic [3:0] OP_SGR    = 4'd8;
    localparam logic [3:0] OP_REPORT = 4'd9;

    localparam logic [2:0] ACT_CURSOR = 3'd0;
    localparam logic [2:0] ACT_CELL   = 3'd1;
    localparam logic [2:0] ACT_SPAN   = 3'd2;
    localparam logic [2:0] ACT_SCROLL = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [8:0] KEY_BKSP  = 9'h100;
    localparam logic [8:0] KEY_LEFT  = 9'h0E4;
    localparam logic [8:0] KEY_RIGHT = 9'h0E5;
    localparam logic [8:0] KEY_DEL   = 9'h0E9;
    localparam logic [8:0] KEY_LF    = 9'h00A;
    localparam logic [8:0] KEY_CR    = 9'h00D;
    localparam logic [8:0] KEY_TAB   = 9'h009;
    localparam logic [8:0] KEY_BS    = 9'h008;

    localparam logic [7:0] CLR_TO_END   = 8'd0;
    localparam logic [7:0] CLR_TO_START = 8'd1;
    localparam logic [7:0] CLR_ALL      = 8'd2;

    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_BLINK      = 8'd5;
    localparam logic [7:0] SGR_NO_BOLD    = 8'd22;
    localparam logic [7:0] SGR_NO_BLINK   = 8'd25;
    localparam logic [7:0] SGR_FG_DEF     = 8'd39;
    localparam logic [7:0] SGR_BG_DEF     = 8'd49;
    localparam logic [7:0] SGR_FG_BASE    = 8'd30;
    localparam logic [7:0] SGR_FG_INTENSE = 8'd90;
    localparam logic [7:0] SGR_BG_BASE    = 8'd40;
    localparam logic [7:0] SGR_BG_BRIGHT  = 8'd100;

    localparam logic [7:0] BLANK      = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam int unsigned TAB_STEP  = 4;

    localparam logic REG_AUTO_SCROLL  = 1'b0;
    localparam logic REG_DEFAULT_ATTR = 1'b1;

    typedef struct packed {
        logic [3:0] op;
        logic [8:0] char_code;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
        logic       final_param;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] row;
        logic [6:0] col_start;
        logic [6:0] col_end;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       bold;
        logic       blink;
        logic [2:0] fg_idx;
        logic       fg_intense;
        logic [2:0] bg_idx;
    } t_sgr;

    localparam t_sgr SGR_STATE_RESET = '{bold: 1'b0, blink: 1'b0, fg_idx: 3'd7,
                                         fg_intense: 1'b0, bg_idx: 3'd0};

    function automatic logic [3:0] colour_map(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0:    v = 4'h0;
            3'd1:    v = 4'h4;
            3'd2:    v = 4'h2;
            3'd3:    v = 4'hE;
            3'd4:    v = 4'h1;
            3'd5:    v = 4'h5;
            3'd6:    v = 4'h3;
            default: v = 4'h7;
        endcase
        return v;
    endfunction

    function automatic t_res mk_res(input logic [2:0] act, input logic [4:0] row,
                                    input logic [6:0] cs, input logic [6:0] ce,
                                    input logic [7:0] ch, input logic [7:0] at,
                                    input logic lst);
        t_res r;
        r.action    = act;
        r.row       = row;
        r.col_start = cs;
        r.col_end   = ce;
        r.cell_char = ch;
        r.cell_attr = at;
        r.last      = lst;
        return r;
    endfunction

endpackage

// ----- rtl/tte_cmd_if.sv -----
// command word channel into the terminal engine
interface tte_cmd_if import tte_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tte_res_if.sv -----
// result word channel out of the terminal engine
interface tte_res_if import tte_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tte_sgr.sv -----
// sgr parameter decode and attribute byte rebuild
module tte_sgr import tte_pkg::*; (
    input  logic [7:0] i_value,
    input  t_sgr       i_sgr,
    output t_sgr       o_sgr,
    output logic [7:0] o_attr
);

    logic [7:0] fg_off, fgb_off, bg_off, bgb_off;
    logic [3:0] fg_col, bg_col;

    assign fg_off  = i_value - SGR_FG_BASE;
    assign fgb_off = i_value - SGR_FG_INTENSE;
    assign bg_off  = i_value - SGR_BG_BASE;
    assign bgb_off = i_value - SGR_BG_BRIGHT;

    always_comb begin
        o_sgr = i_sgr;
        case (i_value) inside
            SGR_RESET:    o_sgr = SGR_STATE_RESET;
            SGR_BOLD:     o_sgr.bold = 1'b1;
            SGR_BLINK:    o_sgr.blink = 1'b1;
            SGR_NO_BOLD:  o_sgr.bold = 1'b0;
            SGR_NO_BLINK: o_sgr.blink = 1'b0;
            SGR_FG_DEF: begin
                o_sgr.fg_idx     = 3'd7;
                o_sgr.fg_intense = 1'b0;
            end
            SGR_BG_DEF:   o_sgr.bg_idx = 3'd0;
            [8'd30:8'd37]: begin
                o_sgr.fg_idx     = fg_off[2:0];
                o_sgr.fg_intense = 1'b0;
            end
            [8'd90:8'd97]: begin
                o_sgr.fg_idx     = fgb_off[2:0];
                o_sgr.fg_intense = 1'b1;
            end
            [8'd40:8'd47]:   o_sgr.bg_idx = bg_off[2:0];
            [8'd100:8'd107]: o_sgr.bg_idx = bgb_off[2:0];
            default: ;
        endcase
    end

    // attribute from the updated flags
    assign fg_col = colour_map(o_sgr.fg_idx) | {(o_sgr.bold | o_sgr.fg_intense), 3'b000};
    assign bg_col = colour_map(o_sgr.bg_idx);
    assign o_attr = {o_sgr.blink, bg_col[2:0], fg_col};

endmodule

// ----- rtl/tte_step.sv -----
// per-word cursor and command logic between input and result registers
module tte_step import tte_pkg::*; #(
    parameter int unsigned COLS = DEF_COLS,
    parameter int unsigned ROWS = DEF_ROWS
) (
    input  t_cmd       i_cmd,
    input  logic [4:0] i_row,
    input  logic [6:0] i_col,
    input  logic [7:0] i_attr,
    input  t_sgr       i_sgr,
    input  logic       i_auto_scroll,
    input  logic [7:0] i_default_attr,
    output t_res       o_res [3],
    output logic [1:0] o_last_idx,
    output logic [4:0] o_row,
    output logic [6:0] o_col,
    output logic [7:0] o_attr,
    output t_sgr       o_sgr
);

    localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
    localparam logic [6:0] LAST_COL = 7'(COLS - 1);
    localparam logic [8:0] ROWS_W   = 9'(ROWS);
    localparam logic [8:0] COLS_W   = 9'(COLS);

    t_sgr       sgr_new;
    logic [7:0] attr_new;
    logic       sgr_en;

    tte_sgr u_sgr (
        .i_value (i_cmd.arg_a),
        .i_sgr   (i_sgr),
        .o_sgr   (sgr_new),
        .o_attr  (attr_new)
    );

    assign sgr_en = (i_cmd.op == OP_SGR);
    assign o_sgr  = sgr_en ? sgr_new : i_sgr;
    assign o_attr = (sgr_en && i_cmd.final_param) ? attr_new : i_attr;

    always_comb begin
        logic [5:0] r;
        logic [7:0] c;
        logic [8:0] sum;
        logic [7:0] tgt;
        logic [1:0] k;
        r      = {1'b0, i_row};
        c      = {1'b0, i_col};
        sum    = '0;
        tgt    = '0;
        k      = 2'd0;
        for (int i = 0; i < 3; i++) begin
            o_res[i] = '0;
        end
        case (i_cmd.op)
            OP_PUT: begin
                case (i_cmd.char_code)
                    KEY_BKSP: begin
                        if (c != 8'd0) begin
                            c = c - 8'd1;
                            if (c == 8'd0 && r != 6'd0) begin
                                c = {1'b0, LAST_COL};
                                r = r - 6'd1;
                            end
                            o_res[k] = mk_res(ACT_CELL, r[4:0], c[6:0], c[6:0], BLANK,
                                              i_attr, 1'b0);
                            k = k + 2'd1;
                        end
                    end
                    KEY_LEFT: begin
                        if (c != 8'd0) c = c - 8'd1;
                    end
                    KEY_RIGHT: begin
                        if (c < {1'b0, LAST_COL}) c = c + 8'd1;
                    end
                    KEY_DEL: begin
                        o_res[k] = mk_res(ACT_CELL, r[4:0], c[6:0], c[6:0], BLANK,
                                          i_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    KEY_LF: begin
                        r = r + 6'd1;
                        c = 8'd0;
                    end
                    KEY_CR: c = 8'd0;
                    KEY_TAB: begin
                        c = c + 8'(TAB_STEP);
                        if ({1'b0, c} >= COLS_W) begin
                            c = 8'd0;
                            r = r + 6'd1;
                        end
                    end
                    KEY_BS: begin
                        if (c != 8'd0) c = c - 8'd1;
                        o_res[k] = mk_res(ACT_CELL, r[4:0], c[6:0], c[6:0], BLANK,
                                          i_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    default: begin
                        o_res[k] = mk_res(ACT_CELL, r[4:0], c[6:0], c[6:0],
                                          i_cmd.char_code[7:0], i_attr, 1'b0);
                        k = k + 2'd1;
                        c = c + 8'd1;
                        if ({1'b0, c} >= COLS_W) begin
                            c = 8'd0;
                            r = r + 6'd1;
                        end
                    end
                endcase
                if ({3'b000, r} >= ROWS_W) begin
                    if (i_auto_scroll) begin
                        o_res[k] = mk_res(ACT_SCROLL, LAST_ROW, 7'd0, LAST_COL, BLANK,
                                          i_default_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    r = {1'b0, LAST_ROW};
                end
            end
            OP_UP: begin
                r = (i_cmd.arg_a >= {2'b00, r}) ? 6'd0 : r - i_cmd.arg_a[5:0];
            end
            OP_DOWN: begin
                sum = {3'b000, r} + {1'b0, i_cmd.arg_a};
                r   = (sum >= ROWS_W) ? {1'b0, LAST_ROW} : sum[5:0];
            end
            OP_LEFT: begin
                c = (i_cmd.arg_a >= c) ? 8'd0 : c - i_cmd.arg_a;
            end
            OP_RIGHT: begin
                sum = {1'b0, c} + {1'b0, i_cmd.arg_a};
                c   = (sum >= COLS_W) ? {1'b0, LAST_COL} : sum[7:0];
            end
            OP_SETPOS: begin
                tgt = (i_cmd.arg_a == 8'd0) ? 8'd0 : i_cmd.arg_a - 8'd1;
                r   = ({1'b0, tgt} >= ROWS_W) ? {1'b0, LAST_ROW} : tgt[5:0];
                tgt = (i_cmd.arg_b == 8'd0) ? 8'd0 : i_cmd.arg_b - 8'd1;
                c   = ({1'b0, tgt} >= COLS_W) ? {1'b0, LAST_COL} : tgt;
            end
            OP_CLS: begin
                if (i_cmd.arg_a == CLR_ALL) begin
                    o_res[k] = mk_res(ACT_CLEAR, 5'd0, 7'd0, LAST_COL, BLANK, i_attr, 1'b0);
                    k = k + 2'd1;
                    r = 6'd0;
                    c = 8'd0;
                end
            end
            OP_CLL: begin
                case (i_cmd.arg_a)
                    CLR_TO_END: begin
                        o_res[k] = mk_res(ACT_SPAN, r[4:0], c[6:0], LAST_COL, BLANK,
                                          i_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    CLR_TO_START: begin
                        o_res[k] = mk_res(ACT_SPAN, r[4:0], 7'd0, c[6:0], BLANK,
                                          i_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    CLR_ALL: begin
                        o_res[k] = mk_res(ACT_SPAN, r[4:0], 7'd0, LAST_COL, BLANK,
                                          i_attr, 1'b0);
                        k = k + 2'd1;
                    end
                    default: ;
                endcase
            end
            OP_SGR: ;
            OP_REPORT: ;
            default: ;
        endcase
        o_res[k]   = mk_res(ACT_CURSOR, r[4:0], c[6:0], c[6:0], 8'd0, o_attr, 1'b1);
        o_last_idx = k;
        o_row      = r[4:0];
        o_col      = c[6:0];
    end

endmodule

// ----- rtl/tte_out_reg.sv -----
// result output register driving the result channel
module tte_out_reg import tte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_res      i_data,
    output logic      o_load,
    tte_res_if.source o_res
);

    logic r_vld;
    t_res r_data;

    assign o_load    = !r_vld || o_res.ready;
    assign o_res.valid = r_vld;
    assign o_res.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- rtl/text_terminal_cursor_engine.sv -----
// top level of the text terminal cursor engine
// usage:
//   i_cmd carries one command word (put char, moves, set position, clears, sgr,
//   report). each word yields one to three result words on o_res: cell writes,
//   span fills, scroll-up or clear commands for the character store, and always
//   a final cursor word with last set.
//   the command word is registered, its results are worked out in one pass of
//   logic and leave through an output register one per cycle while o_res is
//   not stalled. the first result word passes the command register and the
//   output register before it is valid on o_res.
//   throughput: one result word per cycle, so a word with a single result can be
//   taken every cycle while o_res is not stalled.
//   i_cmd.ready drops while the held word still has results to send.
//   a stall on o_res holds the output register, which in turn holds the
//   command register and i_cmd.ready low; nothing is lost or repeated.
//   reset (i_rst_n low, synchronous) homes the cursor, sets attribute 0x07,
//   sgr state to defaults, auto scroll on and default fill attribute 0x07.
//   configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are to be made by
//   the user while the engine is idle; the block itself does not enforce this.
`include "text_terminal_cursor_engine_defines.svh"
module text_terminal_cursor_engine import tte_pkg::*; #(
    parameter int unsigned COLS = DEF_COLS,
    parameter int unsigned ROWS = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    tte_cmd_if.sink    i_cmd,
    tte_res_if.source  o_res
);

    logic       r_cmd_vld;
    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic [4:0] r_row;
    logic [6:0] r_col;
    logic [7:0] r_attr;
    t_sgr       r_sgr;
    logic       r_auto_scroll;
    logic [7:0] r_default_attr;

    t_res       step_res [3];
    logic [1:0] step_last_idx;
    logic [4:0] n_row;
    logic [6:0] n_col;
    logic [7:0] n_attr;
    t_sgr       n_sgr;
    logic       out_load;
    logic       issue;
    logic       done;

    tte_step #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_step (
        .i_cmd          (r_cmd),
        .i_row          (r_row),
        .i_col          (r_col),
        .i_attr         (r_attr),
        .i_sgr          (r_sgr),
        .i_auto_scroll  (r_auto_scroll),
        .i_default_attr (r_default_attr),
        .o_res          (step_res),
        .o_last_idx     (step_last_idx),
        .o_row          (n_row),
        .o_col          (n_col),
        .o_attr         (n_attr),
        .o_sgr          (n_sgr)
    );

    tte_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_data  (step_res[r_idx]),
        .o_load  (out_load),
        .o_res   (o_res)
    );

    assign issue       = r_cmd_vld && out_load;
    assign done        = issue && (r_idx == step_last_idx);
    assign i_cmd.ready = !r_cmd_vld || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            if (i_cmd.ready) begin
                r_cmd_vld <= i_cmd.valid;
            end
            if (done) begin
                r_idx <= 2'd0;
            end else if (issue) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd <= i_cmd.data;
        end
    end

    // terminal state commits with the cursor word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= 5'd0;
            r_col  <= 7'd0;
            r_attr <= ATTR_RESET;
            r_sgr  <= SGR_STATE_RESET;
        end else if (done) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_attr <= n_attr;
            r_sgr  <= n_sgr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_scroll  <= 1'b1;
            r_default_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AUTO_SCROLL:  r_auto_scroll  <= i_cfg_data[0];
                REG_DEFAULT_ATTR: r_default_attr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    `TTE_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_cmd_vld |-> (r_idx <= step_last_idx))
    `TTE_ASSERT(a_done_gives_last, i_clk, i_rst_n, done |=> (o_res.valid && o_res.data.last))
    `TTE_NEVER(a_cursor_off_screen, i_clk, i_rst_n, r_row > 5'(ROWS - 1))
    `TTE_NEVER(a_col_off_screen, i_clk, i_rst_n, r_col > 7'(COLS - 1))
    `TTE_ASSERT(a_mid_word_not_last, i_clk, i_rst_n, (issue && !done) |=> !o_res.data.last)

endmodule

// ----- sim/text_terminal_cursor_engine_tb.sv -----
// self-checking testbench for the text terminal cursor engine
`timescale 1ns / 1ps

module text_terminal_cursor_engine_tb import tte_pkg::*; ();

    class term_scoreboard;
        t_res        expected_q[$];
        int unsigned mismatches;
        int unsigned words_seen;
        int unsigned results_seen;
        int unsigned scrolls_seen;
        logic        scroll_en;
        logic [7:0]  fill_attr;
        int          cur_row;
        int          cur_col;
        logic [7:0]  attr;
        t_sgr        sgr;

        function new();
            scroll_en = 1'b1;
            fill_attr = ATTR_RESET;
            cur_row   = 0;
            cur_col   = 0;
            attr      = ATTR_RESET;
            sgr       = SGR_STATE_RESET;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == REG_AUTO_SCROLL) begin
                scroll_en = val[0];
            end else begin
                fill_attr = val;
            end
        endfunction

        function logic [3:0] palette(logic [2:0] idx);
            case (idx)
                3'd0: return 4'h0;
                3'd1: return 4'h4;
                3'd2: return 4'h2;
                3'd3: return 4'hE;
                3'd4: return 4'h1;
                3'd5: return 4'h5;
                3'd6: return 4'h3;
                default: return 4'h7;
            endcase
        endfunction

        function void apply_sgr(logic [7:0] v);
            if (v == SGR_RESET) begin
                sgr = SGR_STATE_RESET;
            end else if (v == SGR_BOLD) begin
                sgr.bold = 1'b1;
            end else if (v == SGR_BLINK) begin
                sgr.blink = 1'b1;
            end else if (v == SGR_NO_BOLD) begin
                sgr.bold = 1'b0;
            end else if (v == SGR_NO_BLINK) begin
                sgr.blink = 1'b0;
            end else if (v == SGR_FG_DEF) begin
                sgr.fg_idx     = 3'd7;
                sgr.fg_intense = 1'b0;
            end else if (v == SGR_BG_DEF) begin
                sgr.bg_idx = 3'd0;
            end else if (v >= SGR_FG_BASE && v <= SGR_FG_BASE + 8'd7) begin
                sgr.fg_idx     = 3'(v - SGR_FG_BASE);
                sgr.fg_intense = 1'b0;
            end else if (v >= SGR_FG_INTENSE && v <= SGR_FG_INTENSE + 8'd7) begin
                sgr.fg_idx     = 3'(v - SGR_FG_INTENSE);
                sgr.fg_intense = 1'b1;
            end else if (v >= SGR_BG_BASE && v <= SGR_BG_BASE + 8'd7) begin
                sgr.bg_idx = 3'(v - SGR_BG_BASE);
            end else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT + 8'd7) begin
                sgr.bg_idx = 3'(v - SGR_BG_BRIGHT);
            end
        endfunction

        function void rebuild_attr();
            logic [3:0] fg;
            logic [3:0] bg;
            fg = palette(sgr.fg_idx);
            bg = palette(sgr.bg_idx);
            if (sgr.bold || sgr.fg_intense) begin
                fg = fg | 4'h8;
            end
            attr = {sgr.blink, bg[2:0], fg};
        endfunction

        function void queue_result(logic [2:0] act, int r, int cs, int ce,
                                   logic [7:0] ch, logic [7:0] at, logic lst);
            t_res w;
            w.action    = act;
            w.row       = 5'(r);
            w.col_start = 7'(cs);
            w.col_end   = 7'(ce);
            w.cell_char = ch;
            w.cell_attr = at;
            w.last      = lst;
            expected_q.push_back(w);
        endfunction

        function void note_cmd(t_cmd w);
            int r;
            int c;
            int a;
            int b;
            r = cur_row;
            c = cur_col;
            a = w.arg_a;
            b = w.arg_b;
            words_seen++;
            case (w.op)
                OP_PUT: begin
                    case (w.char_code)
                        KEY_BKSP: begin
                            if (c > 0) begin
                                c--;
                                if (c == 0 && r > 0) begin
                                    c = DEF_COLS - 1;
                                    r--;
                                end
                                queue_result(ACT_CELL, r, c, c, BLANK, attr, 1'b0);
                            end
                        end
                        KEY_LEFT: begin
                            if (c > 0) c--;
                        end
                        KEY_RIGHT: begin
                            if (c < DEF_COLS - 1) c++;
                        end
                        KEY_DEL: begin
                            queue_result(ACT_CELL, r, c, c, BLANK, attr, 1'b0);
                        end
                        KEY_LF: begin
                            r++;
                            c = 0;
                        end
                        KEY_CR: begin
                            c = 0;
                        end
                        KEY_TAB: begin
                            c += TAB_STEP;
                            if (c >= DEF_COLS) begin
                                c = 0;
                                r++;
                            end
                        end
                        KEY_BS: begin
                            if (c > 0) c--;
                            queue_result(ACT_CELL, r, c, c, BLANK, attr, 1'b0);
                        end
                        default: begin
                            queue_result(ACT_CELL, r, c, c, w.char_code[7:0], attr, 1'b0);
                            c++;
                            if (c >= DEF_COLS) begin
                                c = 0;
                                r++;
                            end
                        end
                    endcase
                    if (r >= DEF_ROWS) begin
                        if (scroll_en) begin
                            queue_result(ACT_SCROLL, DEF_ROWS - 1, 0, DEF_COLS - 1, BLANK,
                                         fill_attr, 1'b0);
                        end
                        r = DEF_ROWS - 1;
                    end
                end
                OP_UP:    r = (a >= r) ? 0 : r - a;
                OP_DOWN:  r = (r + a >= DEF_ROWS) ? DEF_ROWS - 1 : r + a;
                OP_LEFT:  c = (a >= c) ? 0 : c - a;
                OP_RIGHT: c = (c + a >= DEF_COLS) ? DEF_COLS - 1 : c + a;
                OP_SETPOS: begin
                    r = (a < 1) ? 0 : a - 1;
                    c = (b < 1) ? 0 : b - 1;
                    if (r >= DEF_ROWS) r = DEF_ROWS - 1;
                    if (c >= DEF_COLS) c = DEF_COLS - 1;
                end
                OP_CLS: begin
                    if (w.arg_a == CLR_ALL) begin
                        queue_result(ACT_CLEAR, 0, 0, DEF_COLS - 1, BLANK, attr, 1'b0);
                        r = 0;
                        c = 0;
                    end
                end
                OP_CLL: begin
                    if (w.arg_a == CLR_TO_END) begin
                        queue_result(ACT_SPAN, r, c, DEF_COLS - 1, BLANK, attr, 1'b0);
                    end else if (w.arg_a == CLR_TO_START) begin
                        queue_result(ACT_SPAN, r, 0, c, BLANK, attr, 1'b0);
                    end else if (w.arg_a == CLR_ALL) begin
                        queue_result(ACT_SPAN, r, 0, DEF_COLS - 1, BLANK, attr, 1'b0);
                    end
                end
                OP_SGR: begin
                    apply_sgr(w.arg_a);
                    if (w.final_param) rebuild_attr();
                end
                default: ;
            endcase
            cur_row = r;
            cur_col = c;
            queue_result(ACT_CURSOR, r, c, c, 8'h00, attr, 1'b1);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 30) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("result word %0d %s got 0x%0h want 0x%0h",
                                          results_seen, name, got, want));
            end
        endtask

        task check_res(t_res got);
            t_res want;
            results_seen++;
            if (got.action == ACT_SCROLL) scrolls_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word %0d arrived with nothing pending: %p",
                                          results_seen, got));
            end else begin
                want = expected_q.pop_front();
                compare_field("action", got.action, want.action);
                compare_field("row", got.row, want.row);
                compare_field("col_start", got.col_start, want.col_start);
                compare_field("col_end", got.col_end, want.col_end);
                compare_field("cell_char", got.cell_char, want.cell_char);
                compare_field("cell_attr", got.cell_attr, want.cell_attr);
                compare_field("last", got.last, want.last);
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    tte_cmd_if cmd_ch ();
    tte_res_if res_ch ();

    term_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    text_terminal_cursor_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_res(res_ch.data);
        end
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_cmd cmd_word(logic [3:0] op, logic [8:0] code, logic [7:0] a,
                                      logic [7:0] b, logic fin);
        t_cmd w;
        w.op          = op;
        w.char_code   = code;
        w.arg_a       = a;
        w.arg_b       = b;
        w.final_param = fin;
        return w;
    endfunction

    function automatic logic [7:0] pick_sgr();
        case ($urandom_range(11))
            0: return SGR_RESET;
            1: return SGR_BOLD;
            2: return SGR_BLINK;
            3: return SGR_NO_BOLD;
            4: return SGR_NO_BLINK;
            5: return SGR_FG_DEF;
            6: return SGR_BG_DEF;
            7: return SGR_FG_BASE + 8'($urandom_range(7));
            8: return SGR_FG_INTENSE + 8'($urandom_range(7));
            9: return SGR_BG_BASE + 8'($urandom_range(7));
            10: return SGR_BG_BRIGHT + 8'($urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_cmd random_word();
        t_cmd w;
        int pick;
        w = cmd_word(4'($urandom), 9'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        pick = $urandom_range(99);
        if (pick < 30) begin
            w.op = OP_PUT;
            if ($urandom_range(3) != 0) w.char_code = 9'($urandom_range(32, 126));
        end else if (pick < 46) begin
            w.op = OP_PUT;
            case ($urandom_range(7))
                0: w.char_code = KEY_BKSP;
                1: w.char_code = KEY_LEFT;
                2: w.char_code = KEY_RIGHT;
                3: w.char_code = KEY_DEL;
                4: w.char_code = KEY_LF;
                5: w.char_code = KEY_CR;
                6: w.char_code = KEY_TAB;
                default: w.char_code = KEY_BS;
            endcase
        end else if (pick < 58) begin
            w.op = 4'($urandom_range(OP_UP, OP_RIGHT));
            if ($urandom_range(3) != 0) w.arg_a = 8'($urandom_range(6));
        end else if (pick < 65) begin
            w.op = OP_SETPOS;
            if ($urandom_range(3) != 0) begin
                w.arg_a = 8'($urandom_range(DEF_ROWS + 2));
                w.arg_b = 8'($urandom_range(DEF_COLS + 2));
            end
        end else if (pick < 70) begin
            w.op = OP_CLS;
            if ($urandom_range(1) != 0) w.arg_a = CLR_ALL;
        end else if (pick < 78) begin
            w.op = OP_CLL;
            if ($urandom_range(3) != 0) w.arg_a = 8'($urandom_range(3));
        end else if (pick < 86) begin
            w.op    = OP_SGR;
            w.arg_a = pick_sgr();
        end else if (pick < 91) begin
            w.op = OP_REPORT;
        end else if (pick < 95) begin
            w.op = 4'($urandom_range(10, 15));
        end
        return w;
    endfunction

    task automatic send_word(input t_cmd w);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(w);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        cmd_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic write_regs(input logic scroll_on, input logic [7:0] fill);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_AUTO_SCROLL;
        i_cfg_data <= {7'd0, scroll_on};
        @(posedge i_clk);
        i_cfg_idx  <= REG_DEFAULT_ATTR;
        i_cfg_data <= fill;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(REG_AUTO_SCROLL, {7'd0, scroll_on});
        sb.set_reg(REG_DEFAULT_ATTR, fill);
    endtask

    task automatic run_directed();
        send_word(cmd_word(OP_PUT, 9'h041, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, 9'h1C8, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_BKSP, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_BS, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_BS, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_BKSP, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_LEFT, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_SETPOS, 9'h000, 8'd3, 8'd2, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_BKSP, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_RIGHT, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_TAB, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_DEL, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_SETPOS, 9'h000, 8'd255, 8'd255, 1'b1));
        send_word(cmd_word(OP_PUT, 9'h0FF, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_LF, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_CR, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_UP, 9'h000, 8'd255, 8'd0, 1'b0));
        send_word(cmd_word(OP_DOWN, 9'h000, 8'd255, 8'd0, 1'b0));
        send_word(cmd_word(OP_RIGHT, 9'h000, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(OP_RIGHT, 9'h000, 8'd40, 8'd0, 1'b0));
        send_word(cmd_word(OP_CLL, 9'h000, CLR_TO_END, 8'd0, 1'b0));
        send_word(cmd_word(OP_CLL, 9'h000, CLR_TO_START, 8'd0, 1'b0));
        send_word(cmd_word(OP_CLL, 9'h000, CLR_ALL, 8'd0, 1'b0));
        send_word(cmd_word(OP_CLL, 9'h000, 8'd3, 8'd0, 1'b0));
        send_word(cmd_word(OP_LEFT, 9'h000, 8'd255, 8'd0, 1'b0));
        send_word(cmd_word(OP_SGR, 9'h000, SGR_BOLD, 8'd0, 1'b0));
        send_word(cmd_word(OP_SGR, 9'h000, SGR_FG_INTENSE + 8'd3, 8'd0, 1'b0));
        send_word(cmd_word(OP_SGR, 9'h000, SGR_BG_BRIGHT + 8'd7, 8'd0, 1'b0));
        send_word(cmd_word(OP_SGR, 9'h000, SGR_BLINK, 8'd0, 1'b1));
        send_word(cmd_word(OP_SGR, 9'h000, 8'd200, 8'd0, 1'b1));
        send_word(cmd_word(OP_CLS, 9'h000, CLR_TO_START, 8'd0, 1'b0));
        send_word(cmd_word(OP_CLS, 9'h000, CLR_ALL, 8'd0, 1'b0));
        send_word(cmd_word(OP_SGR, 9'h000, SGR_RESET, 8'd0, 1'b1));
        send_word(cmd_word(OP_REPORT, 9'h000, 8'd0, 8'd0, 1'b0));
        send_word(cmd_word(4'd15, 9'h1FF, 8'd255, 8'd255, 1'b1));
        drain();
        // cursor clamps at the bottom with scrolling off
        write_regs(1'b0, 8'hC3);
        send_word(cmd_word(OP_SETPOS, 9'h000, 8'd25, 8'd80, 1'b0));
        send_word(cmd_word(OP_PUT, KEY_LF, 8'd0, 8'd0, 1'b0));
    endtask

    task automatic run_random(input int n);
        int k;
        int len;
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 12) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    send_word(cmd_word(OP_SGR, 9'($urandom), pick_sgr(), 8'($urandom),
                                       i == len - 1));
                end
                k += len;
            end else begin
                send_word(random_word());
                k++;
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_AUTO_SCROLL;
        i_cfg_data     = 8'd0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        res_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_regs(1'b1, 8'hC3);
        run_directed();

        drain();
        write_regs(1'b1, 8'h00);
        run_random(80);

        drain();
        send_idle_pct <= 77;
        write_regs(1'b0, 8'hFF);
        run_random(80);

        drain();
        send_idle_pct  <= 0;
        recv_stall_pct <= 77;
        write_regs(1'b1, 8'($urandom));
        run_random(80);

        drain();
        send_idle_pct  <= 29;
        recv_stall_pct <= 29;
        write_regs(1'($urandom), 8'($urandom));
        run_random(80);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected result words never arrived",
                                         sb.expected_q.size()));
        end

        $display("covered %0d command words and %0d result words (%0d scrolls)",
                 sb.words_seen, sb.results_seen, sb.scrolls_seen);
        $display("four flow-control phases, auto scroll on and off, several fill attributes");
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for the engine");
        $display("Test completed with failures");
        $finish;
    end

endmodule
